FILE: design/hcep_pkg.sv
`default_nettype none
package hcep_pkg;
	localparam int MaxDim = 8;
	localparam int DimW = 4;
	localparam int HalfW = 17;
	localparam int CoordW = 18;
	// working width for a coordinate during projection (values stay below 2.0)
	localparam int WorkW = 19;
	// tan(22.5 deg) in Q16.16
	localparam int TanW = 15;
	localparam logic [TanW-1:0] TanHalfView = 15'd27146;
	localparam logic [WorkW:0] ThreeQ16 = 20'd196608;
	// numerator magnitude width: tan * |c| < 2^15 * 2^18
	localparam int NumW = 33;
	localparam int DenW = 20;
	localparam int CntW = 6;
	localparam int IdxW = 3;
	localparam int AddrW = 3;

	typedef enum logic [AddrW-1:0] {
		RegDimCount = 3'd0,
		RegHalfSize = 3'd4
	} reg_addr_t;

	typedef enum logic [2:0] {
		StIdle,
		StLoad,
		StMul,
		StDiv,
		StStore,
		StOut
	} state_t;
endpackage
`default_nettype wire

FILE: design/hypercube_edge_projector.sv
`default_nettype none
// Projects one n-cube edge to two 3D endpoints (signed Q16.16). The second endpoint is
// marked last_of_edge. A bad axis or position gives one result with bad_edge set. Work is
// serial. Each coordinate division first multiplies by tan(22.5 deg), one multiplier bit
// per cycle. A restoring divider then gives one quotient bit per cycle, and a store step
// writes the coordinate back. An endpoint takes one load step per projection round (one
// at n=3), plus (n-1)n/2 - 3 divisions and one output step. An edge is accepted once and
// gives two endpoints. One edge is in flight at a time. Input stall stays high until the
// last result of the edge has been taken.
module hypercube_edge_projector (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [hcep_pkg::AddrW-1:0]        paddr,
	input  wire logic [31:0]                       pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [2:0]                        edge_axis,
	input  wire logic [6:0]                        edge_position,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [hcep_pkg::CoordW-1:0]     x_coord,
	output logic signed [hcep_pkg::CoordW-1:0]     y_coord,
	output logic signed [hcep_pkg::CoordW-1:0]     z_coord,
	output logic                                   bad_edge,
	output logic                                   last_of_edge
);
	localparam int W = hcep_pkg::WorkW;

	logic [hcep_pkg::DimW-1:0] dim_q;
	logic [hcep_pkg::HalfW-1:0] half_q;
	hcep_pkg::state_t state_q, state_d;

	logic signed [W-1:0] c_q [hcep_pkg::MaxDim];
	logic [hcep_pkg::IdxW-1:0] k_q;       // current top index (k-1)
	logic [hcep_pkg::IdxW-1:0] i_q;       // coordinate under division
	logic [hcep_pkg::CntW-1:0] cnt_q;
	logic second_q;
	logic [7:0] vert_q;
	logic [2:0] axis_q;
	logic [hcep_pkg::DenW-1:0] den_q;
	logic [hcep_pkg::NumW-1:0] num_q;     // multiplicand shift / quotient shift
	logic [hcep_pkg::NumW-1:0] acc_q;     // product accumulator
	logic [hcep_pkg::TanW-1:0] mul_q;     // multiplier bits
	logic [hcep_pkg::DenW:0] rem_q;
	logic neg_q;

	function automatic logic [hcep_pkg::DenW-1:0] ThreeQ16s();
		return hcep_pkg::ThreeQ16[hcep_pkg::DenW-1:0];
	endfunction
	function automatic logic [W-1:0] cur_mag_at0();
		return c_q[0][W-1] ? W'(-c_q[0]) : c_q[0];
	endfunction

	// clamped dimension
	logic [hcep_pkg::DimW-1:0] n_eff;
	always_comb begin
		n_eff = dim_q;
		if (dim_q < 4'd3) n_eff = 4'd3;
		if (dim_q > 4'(hcep_pkg::MaxDim)) n_eff = 4'(hcep_pkg::MaxDim);
	end

	logic in_acc, out_acc, bad_in;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign bad_in  = ({1'b0, edge_axis} >= n_eff) ||
		({1'b0, edge_position} >= (8'd1 << (n_eff - 4'd1)));

	// vertex with a zero bit inserted at the axis
	logic [7:0] vert_in;
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			if (b < int'(edge_axis)) vert_in[b] = edge_position[b];
			else if (b == int'(edge_axis)) vert_in[b] = 1'b0;
			else if (b > 0) vert_in[b] = (b - 1 < 7) ? edge_position[3'(b - 1)] : 1'b0;
			else vert_in[b] = 1'b0;
		end
	end

	// config port
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		unique case (paddr)
			hcep_pkg::RegDimCount: prdata = 32'(dim_q);
			hcep_pkg::RegHalfSize: prdata = 32'(half_q);
			default: prdata = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= 4'd4;
			half_q <= 17'd65536;
		end else if (psel && penable && pwrite) begin
			if (paddr == hcep_pkg::RegDimCount) dim_q <= pwdata[3:0];
			if (paddr == hcep_pkg::RegHalfSize) half_q <= pwdata[16:0];
		end
	end

	// next state
	logic mul_done, div_done, round_done, proj_done;
	assign mul_done  = (cnt_q == 6'(hcep_pkg::TanW - 1));
	assign div_done  = (cnt_q == 6'(hcep_pkg::NumW - 1));
	assign round_done = (i_q == k_q - 3'd1);
	assign proj_done = (k_q == 3'd2);

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			hcep_pkg::StIdle: begin
				in_stall = 1'b0;
				if (in_valid) state_d = bad_in ? hcep_pkg::StOut : hcep_pkg::StLoad;
			end
			hcep_pkg::StLoad: state_d = proj_done ? hcep_pkg::StOut : hcep_pkg::StMul;
			hcep_pkg::StMul: if (mul_done) state_d = hcep_pkg::StDiv;
			hcep_pkg::StDiv: if (div_done) state_d = hcep_pkg::StStore;
			hcep_pkg::StStore: begin
				if (!round_done) state_d = hcep_pkg::StMul;
				else if (k_q == 3'd3) state_d = hcep_pkg::StOut;
				else state_d = hcep_pkg::StLoad;
			end
			hcep_pkg::StOut: if (out_acc)
				state_d = (last_of_edge) ? hcep_pkg::StIdle : hcep_pkg::StLoad;
			default: state_d = hcep_pkg::StIdle;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= hcep_pkg::StIdle;
		else state_q <= state_d;
	end
	assign out_valid = (state_q == hcep_pkg::StOut);

	// sign-magnitude of the coordinate entering a division
	logic signed [W-1:0] cur;
	logic [W-1:0] cur_mag;
	assign cur = c_q[i_q];
	assign cur_mag = cur[W-1] ? W'(-cur) : cur;

	// restoring divide step
	logic [hcep_pkg::DenW:0] rem_sh;
	assign rem_sh = {rem_q[hcep_pkg::DenW-1:0], num_q[hcep_pkg::NumW-1]};

	logic signed [W-1:0] q_signed;
	assign q_signed = neg_q ? -W'(num_q) : W'(num_q);

	logic signed [W-1:0] hs;
	assign hs = W'({2'b00, half_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			i_q <= '0;
			cnt_q <= '0;
			second_q <= 1'b0;
			bad_edge <= 1'b0;
			vert_q <= '0;
			axis_q <= '0;
			den_q <= '0;
			num_q <= '0;
			acc_q <= '0;
			mul_q <= '0;
			rem_q <= '0;
			neg_q <= 1'b0;
			for (int b = 0; b < hcep_pkg::MaxDim; b++) c_q[b] <= '0;
		end else begin
			unique case (state_q)
				hcep_pkg::StIdle: if (in_acc) begin
					bad_edge <= bad_in;
					second_q <= bad_in;
					k_q <= 3'(n_eff - 4'd1);
					vert_q <= vert_in;
					axis_q <= edge_axis;
					for (int b = 0; b < hcep_pkg::MaxDim; b++)
						c_q[b] <= (b == int'(edge_axis)) ? -hs : (vert_in[b] ? hs : -hs);
				end
				hcep_pkg::StLoad: begin
					den_q <= hcep_pkg::DenW'({c_q[k_q][W-1], c_q[k_q]} + ThreeQ16s());
					i_q <= '0;
					cnt_q <= '0;
					acc_q <= '0;
					num_q <= hcep_pkg::NumW'(cur_mag_at0());
					mul_q <= hcep_pkg::TanHalfView;
					neg_q <= c_q[0][W-1];
				end
				hcep_pkg::StMul: begin
					// shift-add one multiplier bit per cycle
					if (mul_done) begin
						num_q <= mul_q[0] ? acc_q + num_q : acc_q;
						rem_q <= '0;
					end else begin
						if (mul_q[0]) acc_q <= acc_q + num_q;
						num_q <= num_q << 1;
					end
					mul_q <= mul_q >> 1;
					cnt_q <= mul_done ? '0 : cnt_q + 6'd1;
				end
				hcep_pkg::StDiv: begin
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= rem_sh - {1'b0, den_q};
						num_q <= {num_q[hcep_pkg::NumW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						num_q <= {num_q[hcep_pkg::NumW-2:0], 1'b0};
					end
					cnt_q <= div_done ? '0 : cnt_q + 6'd1;
				end
				hcep_pkg::StStore: begin
					c_q[i_q] <= q_signed;
					if (!round_done) begin
						i_q <= i_q + 3'd1;
						acc_q <= '0;
						mul_q <= hcep_pkg::TanHalfView;
						num_q <= hcep_pkg::NumW'(c_q[i_q + 3'd1][W-1] ?
							W'(-c_q[i_q + 3'd1]) : c_q[i_q + 3'd1]);
						neg_q <= c_q[i_q + 3'd1][W-1];
					end else begin
						k_q <= k_q - 3'd1;
					end
				end
				hcep_pkg::StOut: if (out_acc && !last_of_edge) begin
					// rebuild second endpoint
					second_q <= 1'b1;
					k_q <= 3'(n_eff - 4'd1);
					for (int b = 0; b < hcep_pkg::MaxDim; b++)
						c_q[b] <= (b == int'(axis_q) || vert_q[b]) ? hs : -hs;
				end
				default: ;
			endcase
		end
	end

	assign last_of_edge = second_q;
	assign x_coord = bad_edge ? '0 : c_q[0][hcep_pkg::CoordW-1:0];
	assign y_coord = bad_edge ? '0 : c_q[1][hcep_pkg::CoordW-1:0];
	assign z_coord = bad_edge ? '0 : c_q[2][hcep_pkg::CoordW-1:0];

	logic unused;
	assign unused = ^{pwdata[31:17], cur_mag, rem_q[hcep_pkg::DenW]};
endmodule
`default_nettype wire

FILE: design/hcep_checker.sv
`default_nettype none
module hcep_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic bad_edge,
	input wire logic last_of_edge
);
	// a bad result always closes its edge
	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_edge |-> last_of_edge) else $error("bad result not last");
	// no input taken while a result waits
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while output pending");
	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(last_of_edge))
		else $error("output beat dropped");
	// after accepting an input the block goes busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("input not closed");
endmodule

bind hypercube_edge_projector hcep_checker u_hcep_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .bad_edge(bad_edge),
	.last_of_edge(last_of_edge)
);
`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 20000;

	typedef struct packed {
		logic signed [hcep_pkg::CoordW-1:0] x;
		logic signed [hcep_pkg::CoordW-1:0] y;
		logic signed [hcep_pkg::CoordW-1:0] z;
		logic bad;
		logic last;
	} endpoint_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [hcep_pkg::AddrW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] edge_axis = '0;
	logic [6:0] edge_position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [hcep_pkg::CoordW-1:0] x_coord, y_coord, z_coord;
	logic bad_edge, last_of_edge;

	// predictor copy of the registers
	logic [hcep_pkg::DimW-1:0] cfg_dims;
	logic [hcep_pkg::HalfW-1:0] cfg_half;

	endpoint_t pending_points[$];
	int mismatches = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	hypercube_edge_projector uut (.*);

	always #2 clk = ~clk;

	// scale by tan(22.5 deg), then signed division truncated toward zero
	function automatic longint shrink(longint c, longint den);
		longint num;
		longint q;
		num = 64'sd27146 * c;
		q = (num < 0 ? -num : num) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic endpoint_t flatten(longint pt[hcep_pkg::MaxDim], int n);
		endpoint_t e;
		longint den;
		for (int k = n; k > 3; k--) begin
			den = pt[k-1] + 64'sd196608;
			for (int i = 0; i + 1 < k; i++) pt[i] = shrink(pt[i], den);
		end
		e.x = pt[0][hcep_pkg::CoordW-1:0];
		e.y = pt[1][hcep_pkg::CoordW-1:0];
		e.z = pt[2][hcep_pkg::CoordW-1:0];
		e.bad = 1'b0;
		e.last = 1'b0;
		return e;
	endfunction

	task automatic predict_edge(int axis, int pos);
		int n;
		int vtx;
		longint s;
		longint pa[hcep_pkg::MaxDim], pb[hcep_pkg::MaxDim];
		endpoint_t e;
		n = cfg_dims < 3 ? 3 :
			(cfg_dims > hcep_pkg::MaxDim ? hcep_pkg::MaxDim : int'(cfg_dims));
		s = longint'(cfg_half);
		if (axis >= n || pos >= (1 << (n - 1))) begin
			e = '0;
			e.bad = 1'b1;
			e.last = 1'b1;
			pending_points.push_back(e);
		end else begin
			vtx = ((pos >> axis) << (axis + 1)) | (pos & ((1 << axis) - 1));
			for (int i = 0; i < hcep_pkg::MaxDim; i++) begin
				pa[i] = vtx[i] ? s : -s;
				pb[i] = pa[i];
			end
			pa[axis] = -s;
			pb[axis] = s;
			pending_points.push_back(flatten(pa, n));
			e = flatten(pb, n);
			e.last = 1'b1;
			pending_points.push_back(e);
		end
	endtask

	// send one edge beat, with random sender gaps
	task automatic send_edge(int axis, int pos);
		while ($urandom_range(99) < idle_pct) @(posedge clk);
		in_valid <= 1'b1;
		edge_axis <= axis[2:0];
		edge_position <= pos[6:0];
		predict_edge(axis, pos);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_points.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(hcep_pkg::reg_addr_t addr, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == hcep_pkg::RegDimCount) cfg_dims = value[hcep_pkg::DimW-1:0];
		else cfg_half = value[hcep_pkg::HalfW-1:0];
		@(posedge clk);
	endtask

	task automatic configure(int dims, int half);
		drain();
		write_reg(hcep_pkg::RegDimCount, dims);
		write_reg(hcep_pkg::RegHalfSize, half);
	endtask

	// directed: extremes, bad axis and position, clamped dimensions
	task automatic test_directed();
		configure(4, 65536);
		send_edge(0, 0);
		send_edge(3, 7);
		send_edge(2, 5);
		send_edge(4, 0);
		send_edge(0, 8);
		send_edge(7, 127);
		configure(8, 131071);
		send_edge(7, 127);
		send_edge(0, 0);
		send_edge(5, 85);
		send_edge(3, 42);
		configure(0, 0);
		send_edge(2, 3);
		send_edge(0, 4);
		send_edge(3, 0);
		configure(15, 1);
		send_edge(7, 0);
		send_edge(1, 127);
		configure(3, 98304);
		send_edge(1, 2);
		send_edge(2, 1);
		send_edge(1, 4);
	endtask

	// random edges, mostly well formed, over several settings
	task automatic test_random(int count);
		int n;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				configure($urandom_range(15), $urandom_range(131071));
				n = cfg_dims < 3 ? 3 :
					(cfg_dims > hcep_pkg::MaxDim ? hcep_pkg::MaxDim : int'(cfg_dims));
				// high dimensions are slow, keep them rare
				if (n > 5 && $urandom_range(3) != 0) configure($urandom_range(3, 5), cfg_half);
			end
			n = cfg_dims < 3 ? 3 :
				(cfg_dims > hcep_pkg::MaxDim ? hcep_pkg::MaxDim : int'(cfg_dims));
			if ($urandom_range(9) < 8)
				send_edge($urandom_range(n - 1), $urandom_range((1 << (n - 1)) - 1));
			else
				send_edge($urandom_range(7), $urandom_range(127));
		end
	endtask

	// pause until everything has come back, then continue
	task automatic test_pause();
		send_edge(1, 3);
		drain();
		send_edge(2, 1);
	endtask

	// receiver stalls at random
	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	// result check
	always @(posedge clk) begin
		endpoint_t got, want;
		if (out_valid && !out_stall) begin
			got = '{x_coord, y_coord, z_coord, bad_edge, last_of_edge};
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %p", got);
			end else begin
				want = pending_points.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
				end
			end
		end
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		cfg_dims = 4;
		cfg_half = 65536;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pause();
		test_random(430);
		idle_pct = 56;
		test_random(430);
		idle_pct = 0;
		stall_pct = 56;
		test_random(430);
		idle_pct = 24;
		stall_pct = 24;
		test_random(430);
		drain();
		if (mismatches == 0 && pending_points.size() == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
